>>> design/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg: shared types and constants of the register frame responder
// Frame codes, sequence ranges and the reply job handed from front to back.
// ----------------------------------------------------------------------------
package rfr_pkg;

  // frame bytes and reply codes
  localparam logic [7:0] HDR_BYTE   = 8'hFE;
  localparam logic [7:0] CODE_READ  = 8'h11;
  localparam logic [7:0] CODE_WRITE = 8'h33;
  localparam logic [7:0] ACK_OK     = 8'hAA;
  localparam logic [7:0] ACK_BAD    = 8'h55;
  localparam logic [7:0] LEN_READ   = 8'h06;
  localparam logic [7:0] LEN_WRITE  = 8'h05;

  // sequence numbers
  localparam logic [7:0] SEQ_GET_ADDR  = 8'd0;
  localparam logic [7:0] SEQ_GET_BAUD  = 8'd1;
  localparam logic [7:0] SEQ_MEAS_LO   = 8'd2;
  localparam logic [7:0] SEQ_MEAS_HI   = 8'd7;
  localparam logic [7:0] SEQ_SETP_LO   = 8'd8;
  localparam logic [7:0] SEQ_SETP_HI   = 8'd13;
  localparam logic [7:0] SEQ_SET_ADDR  = 8'd14;
  localparam logic [7:0] SEQ_SET_BAUD  = 8'd15;
  localparam logic [7:0] SEQ_WSETP_LO  = 8'd16;
  localparam logic [7:0] SEQ_LAST      = 8'd21;

  localparam logic [7:0] BAUD_MAX      = 8'd2;
  localparam logic [4:0] POS_MAX       = 5'd31;
  localparam int unsigned NUM_SLOTS    = 6;
  localparam int unsigned MAX_LENGTH_DEF = 20;

  // reply byte positions
  localparam logic [3:0] IDX_WR_LAST = 4'd7;
  localparam logic [3:0] IDX_RD_LAST = 4'd8;

  // one reply, fully resolved at frame end
  typedef struct packed {
    logic       is_write;
    logic [7:0] addr;
    logic [7:0] seq;
    logic [7:0] d6;    // value high byte or ack
    logic [7:0] d7;    // value low byte on a read
    logic [1:0] baud;
  } job_t;

  // request toward the queue
  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

endpackage

>>> design/rs485_register_frame_responder.sv
// Register frame responder for an RS-485 link. Input requests are line bytes
// (tuser 0, tlast on the last byte of a frame) or measurement updates
// (tuser 1). The receiver takes one request per clock cycle and resolves a
// frame at its end; an accepted read or write yields a reply of 9 or 8 bytes
// (tlast on the checksum), which the sender emits one byte per cycle while the
// output is ready, from a registered output, while the receiver keeps taking
// requests. The input only stalls when the two-entry reply queue is full,
// i.e. when two complete replies are waiting behind the one being sent.
// ----------------------------------------------------------------------------
// rs485_register_frame_responder: top level
// Frame receiver, reply queue and reply sender on streaming ports.
// ----------------------------------------------------------------------------
module rs485_register_frame_responder import rfr_pkg::*; #(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [10:8] meas_index, [26:11] meas_value, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [0] cmd
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte, [9:8] baud_select, [15:10] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  job_req_t   req;
  job_t       head;
  logic       q_full, q_empty, q_pop, fire;
  logic [7:0] tx_byte;
  logic [1:0] baud;

  assign s_axis_tready = !q_full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  // frame receiver
  rfr_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .cmd_i       (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .frame_end_i (s_axis_tlast),
    .meas_index_i(s_axis_tdata[10:8]),
    .meas_value_i(s_axis_tdata[26:11]),
    .req_o       (req)
  );

  // reply queue
  rfr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (head)
  );

  // reply sender
  rfr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .head_i   (head),
    .pop_o    (q_pop),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tx_byte_o(tx_byte),
    .last_o   (m_axis_tlast),
    .baud_o   (baud)
  );

  assign m_axis_tdata = {6'd0, baud, tx_byte};

`ifndef NO_ASSERTIONS
  // a job is never produced into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req.valid && q_full))
    else $error("reply job lost on full queue");

  // the sender never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty reply queue");

  // reported baud select is always a legal choice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9:8] != 2'd3))
    else $error("illegal baud select in reply");
`endif

endmodule

>>> design/rfr_front.sv
// ----------------------------------------------------------------------------
// rfr_front: frame receiver and register file
// Checks each received byte, keeps the registers, and at frame end resolves
// the command into a reply job.
// ----------------------------------------------------------------------------
module rfr_front import rfr_pkg::*; #(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  input  logic [2:0] meas_index_i,
  input  logic [15:0] meas_value_i,
  output job_req_t   req_o
);

  logic [7:0]  own_addr_q, own_addr_d;
  logic [1:0]  baud_q, baud_d;
  logic [15:0] meas_q [NUM_SLOTS];
  logic [15:0] setp_q [NUM_SLOTS];
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  fld_q [NUM_SLOTS];
  logic [7:0]  fld_n [NUM_SLOTS];
  logic        bad_q, bad_d;

  logic        line_byte, frame_done, in_body, at_cs, accept, make_job;
  logic [8:0]  cs_pos;
  logic [7:0]  len_n, seq, hi, lo, ack;
  logic [15:0] rd_val;
  logic        wr_addr, wr_baud, wr_setp, meas_upd;

  assign line_byte  = fire_i && !cmd_i;
  assign frame_done = line_byte && frame_end_i;
  assign meas_upd   = fire_i && cmd_i && (meas_index_i < 3'(NUM_SLOTS));

  // frame fields as they stand after this byte
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      fld_n[i] = (pos_q == 5'(i + 2)) ? rx_byte_i : fld_q[i];
    end
  end

  assign len_n  = fld_n[0];
  assign seq    = fld_n[2];
  assign hi     = fld_n[4];
  assign lo     = fld_n[5];
  assign cs_pos = {1'b0, len_n} + 9'd2;

  // running checksum over length..checksum
  assign in_body = (pos_q >= 5'd2) && ({4'b0, pos_q} <= cs_pos);
  assign at_cs   = in_body && ({4'b0, pos_q} == cs_pos);
  assign sum_d   = in_body ? sum_q + rx_byte_i : sum_q;
  assign bad_d   = bad_q || ((pos_q < 5'd2) && (rx_byte_i != HDR_BYTE)) ||
                   (at_cs && (sum_d != 8'd0));
  assign pos_d   = (pos_q == POS_MAX) ? pos_q : pos_q + 5'd1;

  assign accept  = !bad_d && ({4'b0, pos_d} >= cs_pos + 9'd1) &&
                   (len_n <= 8'(MAX_LENGTH)) && (fld_n[1] == own_addr_q);
  assign make_job = frame_done && accept && (seq <= SEQ_LAST);

  // read value selection
  always_comb begin
    rd_val = 16'd0;
    if (seq == SEQ_GET_ADDR) begin
      rd_val = {8'd0, own_addr_q};
    end else if (seq == SEQ_GET_BAUD) begin
      rd_val = {14'd0, baud_q};
    end else if (seq inside {[SEQ_MEAS_LO:SEQ_MEAS_HI]}) begin
      rd_val = meas_q[seq[2:0] - 3'd2];
    end else if (seq inside {[SEQ_SETP_LO:SEQ_SETP_HI]}) begin
      rd_val = setp_q[seq[2:0]];
    end
  end

  // write decode
  assign wr_addr = make_job && (seq == SEQ_SET_ADDR) && (hi == 8'd0);
  assign wr_baud = make_job && (seq == SEQ_SET_BAUD) && (hi == 8'd0) &&
                   (lo <= BAUD_MAX);
  assign wr_setp = make_job && (seq >= SEQ_WSETP_LO);
  assign ack     = (((seq == SEQ_SET_ADDR) && !wr_addr) ||
                    ((seq == SEQ_SET_BAUD) && !wr_baud)) ? ACK_BAD : ACK_OK;

  assign own_addr_d = wr_addr ? lo : own_addr_q;
  assign baud_d     = wr_baud ? lo[1:0] : baud_q;

  // job toward the back
  always_comb begin
    req_o.valid        = make_job;
    req_o.job.is_write = (seq >= SEQ_SET_ADDR);
    req_o.job.addr     = own_addr_q;
    req_o.job.seq      = seq;
    req_o.job.d6       = req_o.job.is_write ? ack : rd_val[15:8];
    req_o.job.d7       = rd_val[7:0];
    req_o.job.baud     = baud_d;
  end

  // registers and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= 8'd1;
      baud_q     <= 2'd1;
      pos_q      <= 5'd0;
      sum_q      <= 8'd0;
      bad_q      <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        meas_q[i] <= 16'd0;
        setp_q[i] <= 16'd0;
        fld_q[i]  <= 8'd0;
      end
    end else begin
      own_addr_q <= own_addr_d;
      baud_q     <= baud_d;
      if (meas_upd) begin
        meas_q[meas_index_i] <= meas_value_i;
      end
      if (wr_setp) begin
        setp_q[seq[2:0]] <= {hi, lo};
      end
      if (frame_done) begin
        pos_q <= 5'd0;
        sum_q <= 8'd0;
        bad_q <= 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          fld_q[i] <= 8'd0;
        end
      end else if (line_byte) begin
        pos_q <= pos_d;
        sum_q <= sum_d;
        bad_q <= bad_d;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          fld_q[i] <= fld_n[i];
        end
      end
    end
  end

endmodule

>>> design/rfr_queue.sv
// ----------------------------------------------------------------------------
// rfr_queue: reply job queue
// Two-entry queue between the frame receiver and the reply sender.
// ----------------------------------------------------------------------------
module rfr_queue import rfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  job_req_t req_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output job_t     head_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign push    = req_i.valid && !full_o;
  assign pop     = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_i.job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/rfr_back.sv
// ----------------------------------------------------------------------------
// rfr_back: reply sender
// Serializes one reply job into 8 or 9 bytes with a trailing checksum,
// through a registered output stage.
// ----------------------------------------------------------------------------
module rfr_back import rfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       tvalid_o,
  input  logic       tready_i,
  output logic [7:0] tx_byte_o,
  output logic       last_o,
  output logic [1:0] baud_o
);

  job_t       job_q;
  logic       busy_q;
  logic [3:0] idx_q;
  logic [7:0] sum_q;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       olast_q;
  logic [1:0] obaud_q;

  logic       load_out, is_last;
  logic [7:0] cur_byte, cs;

  assign load_out = busy_q && (!ovalid_q || tready_i);
  assign is_last  = idx_q == (job_q.is_write ? IDX_WR_LAST : IDX_RD_LAST);
  assign cs       = 8'd0 - sum_q;
  assign pop_o    = !empty_i && (!busy_q || (load_out && is_last));

  // reply byte at the current position
  always_comb begin
    case (idx_q)
      4'd0, 4'd1: cur_byte = HDR_BYTE;
      4'd2:       cur_byte = job_q.is_write ? LEN_WRITE : LEN_READ;
      4'd3:       cur_byte = job_q.addr;
      4'd4:       cur_byte = job_q.seq;
      4'd5:       cur_byte = job_q.is_write ? CODE_WRITE : CODE_READ;
      4'd6:       cur_byte = job_q.d6;
      4'd7:       cur_byte = job_q.is_write ? cs : job_q.d7;
      default:    cur_byte = cs;
    endcase
  end

  // job register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
  end

  // sequencing and checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
      sum_q  <= 8'd0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 4'd0;
        sum_q  <= 8'd0;
      end else if (load_out) begin
        busy_q <= !is_last;
        idx_q  <= idx_q + 4'd1;
        if (idx_q >= 4'd2) begin
          sum_q <= sum_q + cur_byte;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      obyte_q <= cur_byte;
      olast_q <= is_last;
      obaud_q <= job_q.baud;
    end
  end

  assign tvalid_o  = ovalid_q;
  assign tx_byte_o = obyte_q;
  assign last_o    = olast_q;
  assign baud_o    = obaud_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: register frame responder
// Sends line bytes and measurement updates into the stream input, and runs an
// in-bench copy of the frame receiver that predicts every reply byte. Starts
// with a short table of directed requests, then mostly well-formed random
// frames with damaged frames, noise and measurement updates mixed in. Both
// stream sides idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import rfr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned TAIL_CYCLES  = 40;

  // one input request as the block sees it
  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic        last;
    logic [2:0]  idx;
    logic [15:0] val;
  } line_req_t;

  // directed row: request plus the reply data bytes where they are obvious
  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic        last;
    logic [2:0]  idx;
    logic [15:0] val;
    logic        typed;
    logic [7:0]  d6;
    logic [7:0]  d7;
  } stim_row_t;

  // one reply byte on the output stream
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic [1:0] baud;
  } reply_byte_t;

  localparam stim_row_t STIM_TABLE [0:24] = '{
    // measurement slot 5 to full scale, frame end flag has no effect
    '{1'b1, 8'h00, 1'b1, 3'd5, 16'hFFFF, 1'b0, 8'h00, 8'h00},
    // slot 7 does not exist and is dropped
    '{1'b1, 8'hFF, 1'b0, 3'd7, 16'h0000, 1'b0, 8'h00, 8'h00},
    // read the address right after reset: zero length, no checksum byte
    '{1'b0, HDR_BYTE, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, HDR_BYTE, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h01, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, SEQ_GET_ADDR, 1'b1, 3'd0, 16'h0000, 1'b1, 8'h00, 8'h01},
    // read back the last measurement slot
    '{1'b0, HDR_BYTE, 1'b0, 3'd7, 16'hFFFF, 1'b0, 8'h00, 8'h00},
    '{1'b0, HDR_BYTE, 1'b0, 3'd7, 16'hFFFF, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 3'd7, 16'hFFFF, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h01, 1'b0, 3'd7, 16'hFFFF, 1'b0, 8'h00, 8'h00},
    '{1'b0, SEQ_MEAS_HI, 1'b1, 3'd7, 16'hFFFF, 1'b1, 8'hFF, 8'hFF},
    // baud select 3 is out of range and refused
    '{1'b0, HDR_BYTE, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, HDR_BYTE, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h01, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, SEQ_SET_BAUD, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, CODE_WRITE, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h03, 1'b1, 3'd0, 16'h0000, 1'b1, ACK_BAD, 8'h00},
    // broken header, no reply
    '{1'b0, 8'h00, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, HDR_BYTE, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h00, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, 8'h01, 1'b0, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00},
    '{1'b0, SEQ_GET_ADDR, 1'b1, 3'd0, 16'h0000, 1'b0, 8'h00, 8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] rx_byte, [10:8] meas_index, [26:11] meas_value, [31:27] zero
  logic [31:0] s_axis_tdata = '0;
  // [0] cmd
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] tx_byte, [9:8] baud_select, [15:10] zero
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predicted register file and frame receiver
  logic [7:0]  node_addr;
  logic [1:0]  baud_sel;
  logic [15:0] meas_regs [NUM_SLOTS];
  logic [15:0] setp_regs [NUM_SLOTS];
  logic [4:0]  rx_pos;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_fields [6];
  logic        rx_bad;

  reply_byte_t reply_bytes_q [$];
  int unsigned n_accepted = 0;
  int unsigned burst_left = 0;
  int unsigned n_mismatch = 0;
  bit          hold_off_req = 1'b0;

  rs485_register_frame_responder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // reset values of the predicted state
  initial begin
    node_addr = 8'd1;
    baud_sel  = 2'd1;
    rx_pos    = '0;
    rx_sum    = '0;
    rx_bad    = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      meas_regs[i] = '0;
      setp_regs[i] = '0;
      rx_fields[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // advance the predicted receiver by one accepted request and queue the reply
  task automatic predict_reply(input line_req_t r, input bit typed,
                               input logic [7:0] t_d6, input logic [7:0] t_d7);
    logic [7:0]  len, seq, hi, lo, old_addr, d6, d7, sum;
    logic [15:0] v;
    logic        accept, is_wr;
    logic [7:0]  frame [9];
    int unsigned p, n;
    reply_byte_t rb;
    if (r.cmd) begin
      if (r.idx < NUM_SLOTS) meas_regs[r.idx] = r.val;
      return;
    end
    p = rx_pos;
    if (p < 2 && r.rx_byte != HDR_BYTE) rx_bad = 1'b1;
    if (p >= 2 && p <= 7) rx_fields[p - 2] = r.rx_byte;
    if (p >= 2 && p <= 2 + rx_fields[0]) begin
      rx_sum = rx_sum + r.rx_byte;
      if (p == 2 + rx_fields[0] && rx_sum != 8'h00) rx_bad = 1'b1;
    end
    if (p < POS_MAX) rx_pos = rx_pos + 5'd1;
    if (!r.last) return;

    // frame end: decide, then clear the frame state whatever the outcome
    len = rx_fields[0];
    seq = rx_fields[2];
    hi  = rx_fields[4];
    lo  = rx_fields[5];
    accept = !rx_bad && (rx_pos >= len + 3) && (len <= MAX_LENGTH_DEF) &&
             (rx_fields[1] == node_addr);
    rx_pos = '0;
    rx_sum = '0;
    rx_bad = 1'b0;
    for (int i = 0; i < 6; i++) rx_fields[i] = '0;
    if (!accept || seq > SEQ_LAST) return;

    old_addr = node_addr;
    d7 = 8'h00;
    if (seq < SEQ_SET_ADDR) begin
      is_wr = 1'b0;
      if (seq == SEQ_GET_ADDR) v = {8'h00, node_addr};
      else if (seq == SEQ_GET_BAUD) v = {14'd0, baud_sel};
      else if (seq <= SEQ_MEAS_HI) v = meas_regs[seq - SEQ_MEAS_LO];
      else v = setp_regs[seq - SEQ_SETP_LO];
      d6 = v[15:8];
      d7 = v[7:0];
    end else begin
      is_wr = 1'b1;
      d6 = ACK_OK;
      if (seq == SEQ_SET_ADDR) begin
        if (hi != 8'h00) d6 = ACK_BAD;
        else node_addr = lo;
      end else if (seq == SEQ_SET_BAUD) begin
        if (hi != 8'h00 || lo > BAUD_MAX) d6 = ACK_BAD;
        else baud_sel = lo[1:0];
      end else begin
        setp_regs[seq - SEQ_WSETP_LO] = {hi, lo};
      end
    end
    if (typed) begin
      d6 = t_d6;
      d7 = t_d7;
    end

    // assemble the reply; the checksum closes the length..data sum to zero
    n = is_wr ? 8 : 9;
    frame[0] = HDR_BYTE;
    frame[1] = HDR_BYTE;
    frame[2] = is_wr ? LEN_WRITE : LEN_READ;
    frame[3] = old_addr;
    frame[4] = seq;
    frame[5] = is_wr ? CODE_WRITE : CODE_READ;
    frame[6] = d6;
    frame[7] = d7;
    sum = 8'h00;
    for (int i = 2; i < n - 1; i++) sum = sum + frame[i];
    frame[n - 1] = 8'h00 - sum;
    for (int k = 0; k < n; k++) begin
      rb.tx   = frame[k];
      rb.last = (k == n - 1);
      rb.baud = baud_sel;
      reply_bytes_q.push_back(rb);
    end
  endtask

  // offer one request in bursts with random gaps, wait for the handshake
  task automatic send_req(input line_req_t r, input bit typed,
                          input logic [7:0] t_d6, input logic [7:0] t_d7);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, r.val, r.idx, r.rx_byte};
    s_axis_tuser  <= r.cmd;
    s_axis_tlast  <= r.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_reply(r, typed, t_d6, t_d7);
    n_accepted++;
  endtask

  // lower the input and let every predicted reply byte come out
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (reply_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  // one random frame; plain_read gives a clean short read with no extras
  task automatic send_frame(input bit plain_read);
    logic [7:0]  body [$];
    logic [7:0]  seq, addr, hi, lo, len, sum;
    int unsigned style, keep, damage, n_extra, pick;
    line_req_t   r;
    seq = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(22, 255))
                                       : 8'($urandom_range(0, 21));
    if (plain_read) seq = 8'($urandom_range(0, 13));
    addr = (!plain_read && $urandom_range(0, 9) == 0) ? 8'($urandom) : node_addr;
    hi = 8'($urandom);
    lo = 8'($urandom);
    if ((seq == SEQ_SET_ADDR || seq == SEQ_SET_BAUD) && $urandom_range(0, 3) != 0)
      hi = 8'h00;
    if (seq == SEQ_SET_BAUD && $urandom_range(0, 3) != 0) lo = 8'($urandom_range(0, 3));
    style = plain_read ? 0 : $urandom_range(0, 99);

    if (style < 35) begin
      // zero length: the length byte is its own checksum, fields still land
      body.push_back(HDR_BYTE);
      body.push_back(HDR_BYTE);
      body.push_back(8'h00);
      body.push_back(addr);
      body.push_back(seq);
      body.push_back((seq < SEQ_SET_ADDR) ? CODE_READ : CODE_WRITE);
      body.push_back(hi);
      body.push_back(lo);
      keep = (seq >= SEQ_SET_ADDR) ? 8 : 5;
      if (!plain_read && $urandom_range(0, 4) == 0) keep = $urandom_range(3, 8);
      while (body.size() > keep) void'(body.pop_back());
    end else if (style < 90) begin
      // full frame with a correct checksum, sometimes over the length limit
      n_extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 14) : $urandom_range(0, 2);
      if (style >= 82) n_extra = $urandom_range(15, 22);
      len = 8'(6 + n_extra);
      body.push_back(HDR_BYTE);
      body.push_back(HDR_BYTE);
      body.push_back(len);
      body.push_back(addr);
      body.push_back(seq);
      body.push_back((seq < SEQ_SET_ADDR) ? CODE_READ : CODE_WRITE);
      body.push_back(hi);
      body.push_back(lo);
      repeat (n_extra) body.push_back(8'($urandom));
      sum = 8'h00;
      for (int i = 2; i < body.size(); i++) sum = sum + body[i];
      body.push_back(8'h00 - sum);
    end else begin
      // line noise
      repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
    end

    // occasional damage: header, checksum, truncation, trailing bytes, overrun
    if (!plain_read && style < 90) begin
      damage = $urandom_range(0, 99);
      if (damage < 6) begin
        pick = $urandom_range(0, 1);
        body[pick] = body[pick] ^ 8'h21;
      end else if (damage < 12) begin
        body[body.size() - 1] = body[body.size() - 1] + 8'd1;
      end else if (damage < 18) begin
        repeat ($urandom_range(1, 3)) if (body.size() > 1) void'(body.pop_back());
      end else if (damage < 24) begin
        repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      end else if (damage < 28) begin
        while (body.size() < 34) body.push_back(8'($urandom));
      end
    end

    foreach (body[i]) begin
      if (!plain_read && $urandom_range(0, 11) == 0) begin
        r.cmd     = 1'b1;
        r.rx_byte = 8'($urandom);
        r.last    = 1'($urandom);
        r.idx     = 3'($urandom);
        r.val     = 16'($urandom);
        send_req(r, 1'b0, 8'h00, 8'h00);
      end
      r.cmd     = 1'b0;
      r.rx_byte = body[i];
      r.last    = (i == body.size() - 1);
      r.idx     = 3'($urandom);
      r.val     = 16'($urandom);
      send_req(r, 1'b0, 8'h00, 8'h00);
    end
  endtask

  task automatic log_mismatch(input string what, input reply_byte_t want,
                              input reply_byte_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%0t: %s: expected tx %02h last %0b baud %0d, got tx %02h last %0b baud %0d",
               $time, what, want.tx, want.last, want.baud, got.tx, got.last, got.baud);
  endtask

  // output side: compare each reply byte with the oldest prediction
  always @(posedge clk_i) begin : reply_check
    reply_byte_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.tx   = m_axis_tdata[7:0];
      got.last = m_axis_tlast;
      got.baud = m_axis_tdata[9:8];
      if (reply_bytes_q.size() == 0) begin
        log_mismatch("reply byte with nothing pending", '0, got);
      end else begin
        want = reply_bytes_q.pop_front();
        if (got !== want) log_mismatch("reply byte mismatch", want, got);
      end
    end
  end

  // output side stalls: random patterns, plus one long hold-off on request
  initial begin : receiver
    int unsigned mode, span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end else begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // stimulus: directed table, then random frames with one fill-up phase
  initial begin : stimulus
    line_req_t r;
    bit        pressed;
    pressed = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (STIM_TABLE[i]) begin
      r.cmd     = STIM_TABLE[i].cmd;
      r.rx_byte = STIM_TABLE[i].rx_byte;
      r.last    = STIM_TABLE[i].last;
      r.idx     = STIM_TABLE[i].idx;
      r.val     = STIM_TABLE[i].val;
      send_req(r, STIM_TABLE[i].typed, STIM_TABLE[i].d6, STIM_TABLE[i].d7);
    end
    drain_replies();

    while (n_accepted < $size(STIM_TABLE) + RANDOM_ITEMS) begin
      if (!pressed && n_accepted > $size(STIM_TABLE) + RANDOM_ITEMS / 2) begin
        // hold the output while back-to-back reads pile up behind it
        pressed = 1'b1;
        drain_replies();
        hold_off_req = 1'b1;
        burst_left = 1000;
        repeat (8) send_frame(1'b1);
        burst_left = 0;
      end else begin
        send_frame(1'b0);
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
